// ----- rtl/sia_pkg.sv -----
// Shared types and constants for the sparse initialised array.
// No dependencies; imported by the controller, datapath and top level.
package sia_pkg;

	localparam int INDEX_W   = 7;
	localparam int VALUE_W   = 32;
	localparam int DEPTH_DEF = 128;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_PROBE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_DECIDE
	} sia_state_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} sia_cmd_t;

	typedef struct packed {
		logic out_full;
	} sia_stat_t;

endpackage

// ----- rtl/sia_ctrl.sv -----
// Controller state machine for the sparse initialised array.
// Depends on sia_pkg; drives commands to sia_dpath.
module sia_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sia_pkg::sia_stat_t  stat,
	output sia_pkg::sia_cmd_t   cmd
);
	import sia_pkg::*;

	sia_state_t state_q;
	sia_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!stat.out_full) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_LOOKUP: begin
				in_stall = 1'b1;
			end
			ST_DECIDE: begin
				cmd.commit = !stat.out_full;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// ----- rtl/sia_dpath.sv -----
// Datapath for the sparse initialised array: index map, slot list,
// value store, slot count and result register. Depends on sia_pkg.
module sia_dpath #(
	parameter int DEPTH = sia_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sia_pkg::sia_cmd_t                   cmd,
	output sia_pkg::sia_stat_t                  stat,
	input  logic                                mode,
	input  logic [sia_pkg::INDEX_W-1:0]         index,
	input  logic signed [sia_pkg::VALUE_W-1:0]  value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                initialized,
	output logic signed [sia_pkg::VALUE_W-1:0]  read_value,
	output logic                                status
);
	import sia_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [AW-1:0]             map_mem  [DEPTH];
	logic [INDEX_W-1:0]        list_mem [DEPTH];
	logic signed [VALUE_W-1:0] val_mem  [DEPTH];

	logic                      mode_q;
	logic [INDEX_W-1:0]        index_q;
	logic signed [VALUE_W-1:0] value_q;
	logic                      in_range_q;
	logic [AW-1:0]             addr_q;
	logic [AW-1:0]             slot_q;
	logic signed [VALUE_W-1:0] stored_q;
	logic [INDEX_W-1:0]        owner_q;
	logic [CW-1:0]             count_q;
	logic                      out_valid_q;
	logic                      init_q;
	logic signed [VALUE_W-1:0] rd_q;
	logic                      status_q;

	logic                      hit;
	logic                      full;
	logic                      do_store;
	logic                      do_claim;
	logic                      res_init;
	logic signed [VALUE_W-1:0] res_rd;
	logic                      res_status;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q     <= mode;
			index_q    <= index;
			value_q    <= value;
			in_range_q <= (32'(index) < DEPTH);
			addr_q     <= AW'(index);
			slot_q     <= map_mem[AW'(index)];
			stored_q   <= val_mem[AW'(index)];
		end
		owner_q <= list_mem[slot_q];
	end

	assign hit  = in_range_q && (CW'(slot_q) < count_q) && (owner_q == index_q);
	assign full = (count_q == CW'(DEPTH));
	assign do_store = (mode_q == MODE_WRITE) && in_range_q && (hit || !full);
	assign do_claim = (mode_q == MODE_WRITE) && in_range_q && !hit && !full;

	always_comb begin
		if (mode_q == MODE_WRITE) begin
			res_init   = do_store;
			res_rd     = do_store ? value_q : '0;
			res_status = in_range_q && !hit && full;
		end else begin
			res_init   = hit;
			res_rd     = hit ? stored_q : '0;
			res_status = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && do_store) begin
			val_mem[addr_q] <= value_q;
		end
		if (cmd.commit && do_claim) begin
			list_mem[AW'(count_q)] <= index_q;
			map_mem[addr_q]        <= AW'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit && do_claim) count_q <= count_q + CW'(1);
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			init_q   <= res_init;
			rd_q     <= res_rd;
			status_q <= res_status;
		end
	end

	assign stat.out_full = out_valid_q && out_stall;
	assign out_valid     = out_valid_q;
	assign initialized   = init_q;
	assign read_value    = rd_q;
	assign status        = status_q;

endmodule

// ----- rtl/sparse_initialized_array_top.sv -----
// Top level of the sparse initialised array: controller plus datapath.
// Depends on sia_pkg, sia_ctrl and sia_dpath.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------
//   in      | in_valid / in_stall | mode, index, value
//   out     | out_valid/out_stall | initialized, read_value, status
//
// Each item takes three steps: accept with index map read, slot list read
// at the mapped slot, then decision with memory writes and result load.
// One item is in flight at a time; a finished result waits in the output
// register while the next item is accepted.
// Reset clears the slot count and handshake state; memories are never cleared.
// A stalled result holds the decision cycle until the register frees.
module sparse_initialized_array_top #(
	parameter int DEPTH = sia_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode,
	input  logic [sia_pkg::INDEX_W-1:0]         index,
	input  logic signed [sia_pkg::VALUE_W-1:0]  value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                initialized,
	output logic signed [sia_pkg::VALUE_W-1:0]  read_value,
	output logic                                status
);
	import sia_pkg::*;

	sia_cmd_t  cmd;
	sia_stat_t stat;

	sia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	sia_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.mode        (mode),
		.index       (index),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.initialized (initialized),
		.read_value  (read_value),
		.status      (status)
	);

endmodule
